### sv/dtf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: shared package
// Character codes, parser phase encoding and the flag group that passes
// from the parser to the result formatter.
// ----------------------------------------------------------------------------
package dtf_pkg;

  // Character codes the parser reacts to.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_DIGIT9 = 8'h39;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_INT  = 2'd1,
    PH_FRAC = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  // Status of a finished string, handed to the formatter.
  typedef struct packed {
    logic active;     // at least one digit was seen
    logic negative;   // a minus sign came before the first digit
    logic saturated;  // integer part overflowed
  } dtf_flags_t;

endpackage

### sv/dtf_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character channel
// Valid/ready channel that carries one text byte per transaction.
// ----------------------------------------------------------------------------
interface dtf_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

### sv/dtf_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one fixed-point number and its
// overflow flag per transaction.
// ----------------------------------------------------------------------------
interface dtf_result_if #(
  parameter int VALUE_W = 33
);
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink (input valid, input value, input overflow, output ready);
endinterface

### sv/dtf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text parser
// Registers each incoming character, then advances the phase machine and
// the integer and fraction accumulators by one character per cycle while
// the pipeline may advance. A terminator copies the accumulated number into
// a record register and clears the parse state.
// ----------------------------------------------------------------------------
module dtf_parser #(
  parameter int INT_BITS        = 16,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  dtf_char_if.sink               chars,
  input  logic                   adv,
  output logic                   rec_valid,
  output dtf_pkg::dtf_flags_t    rec_flags,
  output logic [INT_BITS-1:0]    rec_int,
  output logic [FRAC_BITS+3:0]   rec_frac
);

  localparam int FA = FRAC_BITS + 4;
  localparam int NW = INT_BITS + 4;

  // Fraction weights: round(2^FRAC_BITS / 10^k) for digit position k.
  localparam logic [63:0] SCALE2 = 64'd1 << (FRAC_BITS + 1);
  localparam logic [FRAC_BITS-1:0] WGT [0:15] = '{
    FRAC_BITS'(0),
    FRAC_BITS'((SCALE2 / 64'd10 + 64'd1) >> 1),
    FRAC_BITS'((SCALE2 / 64'd100 + 64'd1) >> 1),
    FRAC_BITS'((SCALE2 / 64'd1000 + 64'd1) >> 1),
    FRAC_BITS'((SCALE2 / 64'd10000 + 64'd1) >> 1),
    FRAC_BITS'((SCALE2 / 64'd100000 + 64'd1) >> 1),
    FRAC_BITS'((SCALE2 / 64'd1000000 + 64'd1) >> 1),
    FRAC_BITS'((SCALE2 / 64'd10000000 + 64'd1) >> 1),
    FRAC_BITS'((SCALE2 / 64'd100000000 + 64'd1) >> 1),
    FRAC_BITS'((SCALE2 / 64'd1000000000 + 64'd1) >> 1),
    FRAC_BITS'(0), FRAC_BITS'(0), FRAC_BITS'(0),
    FRAC_BITS'(0), FRAC_BITS'(0), FRAC_BITS'(0)
  };

  // Input register.
  logic       c_valid;
  logic [7:0] c_q;

  // Parse state.
  dtf_pkg::phase_t     phase, phase_next;
  logic                negative, negative_next;
  logic [INT_BITS-1:0] int_acc, int_acc_next;
  logic [FA-1:0]       frac_acc, frac_acc_next;
  logic [3:0]          digit_cnt, digit_cnt_next;
  logic                saturated, saturated_next;

  logic                step;
  logic                term;
  logic                is_digit;
  logic [3:0]          d;
  logic [NW-1:0]       int_x10;
  logic                int_ovf;
  logic [3:0]          cnt_inc;
  logic [FA-1:0]       prod;
  logic                frac_room;

  // The input register frees up whenever its character moves on.
  assign chars.ready = !c_valid || adv;
  assign step        = c_valid && adv;
  assign term        = (c_q == dtf_pkg::CH_NUL);

  // Character decode and arithmetic for one step.
  assign is_digit  = (c_q >= dtf_pkg::CH_DIGIT0) && (c_q <= dtf_pkg::CH_DIGIT9);
  assign d         = 4'(c_q - dtf_pkg::CH_DIGIT0);
  assign int_x10   = (NW'(int_acc) << 3) + (NW'(int_acc) << 1) + NW'(d);
  assign int_ovf   = |int_x10[NW-1:INT_BITS];
  assign cnt_inc   = digit_cnt + 4'd1;
  assign prod      = FA'(d) * FA'(WGT[cnt_inc]);
  assign frac_room = (digit_cnt < 4'(MAX_FRAC_DIGITS));

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (step) begin
      if (term) begin
        phase_next = dtf_pkg::PH_LEAD;
      end else begin
        unique case (phase)
          dtf_pkg::PH_LEAD: if (is_digit) phase_next = dtf_pkg::PH_INT;
          dtf_pkg::PH_INT:  if (!is_digit) phase_next = dtf_pkg::PH_FRAC;
          dtf_pkg::PH_FRAC: if (!is_digit) phase_next = dtf_pkg::PH_SKIP;
          dtf_pkg::PH_SKIP: phase_next = dtf_pkg::PH_SKIP;
          default:          phase_next = dtf_pkg::PH_LEAD;
        endcase
      end
    end
  end

  // Accumulator updates for the current phase.
  always_comb begin
    negative_next  = negative;
    int_acc_next   = int_acc;
    frac_acc_next  = frac_acc;
    digit_cnt_next = digit_cnt;
    saturated_next = saturated;
    if (step) begin
      if (term) begin
        negative_next  = 1'b0;
        int_acc_next   = '0;
        frac_acc_next  = '0;
        digit_cnt_next = '0;
        saturated_next = 1'b0;
      end else begin
        unique case (phase)
          dtf_pkg::PH_LEAD: begin
            if (is_digit) begin
              int_acc_next = INT_BITS'(d);
            end else if (c_q == dtf_pkg::CH_MINUS) begin
              negative_next = 1'b1;
            end
          end
          dtf_pkg::PH_INT: begin
            if (is_digit) begin
              if (saturated || int_ovf) begin
                int_acc_next   = '1;
                saturated_next = 1'b1;
              end else begin
                int_acc_next = int_x10[INT_BITS-1:0];
              end
            end
          end
          dtf_pkg::PH_FRAC: begin
            if (is_digit && frac_room) begin
              digit_cnt_next = cnt_inc;
              frac_acc_next  = frac_acc + prod;
            end
          end
          dtf_pkg::PH_SKIP: ;
          default: ;
        endcase
      end
    end
  end

  // Control and parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid   <= 1'b0;
      rec_valid <= 1'b0;
      phase     <= dtf_pkg::PH_LEAD;
      negative  <= 1'b0;
      int_acc   <= '0;
      frac_acc  <= '0;
      digit_cnt <= '0;
      saturated <= 1'b0;
    end else begin
      if (chars.ready) begin
        c_valid <= chars.valid;
      end
      if (adv) begin
        rec_valid <= c_valid && term;
      end
      phase     <= phase_next;
      negative  <= negative_next;
      int_acc   <= int_acc_next;
      frac_acc  <= frac_acc_next;
      digit_cnt <= digit_cnt_next;
      saturated <= saturated_next;
    end
  end

  // Payload registers: incoming character and finished-string record.
  always_ff @(posedge clk) begin
    if (chars.ready) begin
      c_q <= chars.ch;
    end
    if (step && term) begin
      rec_flags.active    <= (phase != dtf_pkg::PH_LEAD);
      rec_flags.negative  <= negative;
      rec_flags.saturated <= saturated;
      rec_int             <= int_acc;
      rec_frac            <= frac_acc;
    end
  end

endmodule

### sv/dtf_format.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result formatter
// Joins the integer and clamped fraction parts, applies saturation and the
// sign, and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module dtf_format #(
  parameter int INT_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rec_valid,
  input  dtf_pkg::dtf_flags_t  rec_flags,
  input  logic [INT_BITS-1:0]  rec_int,
  input  logic [FRAC_BITS+3:0] rec_frac,
  output logic                 adv,
  dtf_result_if.source         results
);

  localparam int MW = INT_BITS + FRAC_BITS;
  localparam int TB = (MW > 63) ? 63 : MW;
  localparam int VW = MW + 1;
  localparam logic [MW-1:0] MAXMAG = {MW{1'b1}} >> (MW - TB);

  logic                 o_valid;
  logic [FRAC_BITS-1:0] fclamp;
  logic [MW-1:0]        mag_raw;
  logic [MW-1:0]        mag;
  logic [TB:0]          res;
  logic                 ovf;

  // The pipeline moves whenever the output register is empty or being taken.
  assign adv           = !o_valid || results.ready;
  assign results.valid = o_valid;

  // Magnitude with fraction clamp and saturation.
  always_comb begin
    fclamp  = (|rec_frac[FRAC_BITS+3:FRAC_BITS]) ? '1 : rec_frac[FRAC_BITS-1:0];
    mag_raw = {rec_int, fclamp};
    ovf     = 1'b0;
    if (!rec_flags.active) begin
      mag = '0;
    end else if (rec_flags.saturated) begin
      mag = MAXMAG;
      ovf = 1'b1;
    end else if (mag_raw > MAXMAG) begin
      mag = MAXMAG;
    end else begin
      mag = mag_raw;
    end
    res = {1'b0, mag[TB-1:0]};
    if (rec_flags.active && rec_flags.negative) begin
      res = -res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rec_valid) begin
      results.value    <= VW'(res);
      results.overflow <= ovf;
    end
  end

endmodule

### sv/decimal_text_to_fixed_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point
// Parses a stream of decimal characters into a signed fixed-point number.
// ----------------------------------------------------------------------------
// Usage:
//   chars carries one byte per transaction. Bytes before the first digit are
//   skipped (a minus among them makes the result negative), digits form the
//   integer part, the next byte is the separator, and up to MAX_FRAC_DIGITS
//   digits form the fraction. A zero byte ends the string.
//   results carries one transaction per zero byte: value is two's complement
//   with FRAC_BITS fraction bits, saturated, and overflow flags an integer
//   part wider than INT_BITS bits.
//   Throughput is one character per cycle while the receiver does not stall,
//   set by the update of the parse accumulators on every accepted character.
//   The input register takes the terminator, the record register then takes
//   the result, and the output register takes it from there and marks it valid.
//   Reset (synchronous, active high) clears the parse state and drops any
//   pending result. When the receiver stalls, the output register holds its
//   transaction and the stages behind it hold too; chars.ready falls only
//   once a character is waiting in the input register.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point #(
  parameter int INT_BITS        = 16,
  parameter int FRAC_BITS       = 16,
  parameter int MAX_FRAC_DIGITS = 5
) (
  input  logic         clk,
  input  logic         rst,
  dtf_char_if.sink     chars,
  dtf_result_if.source results
);

  logic                  adv;
  logic                  rec_valid;
  dtf_pkg::dtf_flags_t   rec_flags;
  logic [INT_BITS-1:0]   rec_int;
  logic [FRAC_BITS+3:0]  rec_frac;

  // Character register and phase machine.
  dtf_parser #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .adv       (adv),
    .rec_valid (rec_valid),
    .rec_flags (rec_flags),
    .rec_int   (rec_int),
    .rec_frac  (rec_frac)
  );

  // Sign, saturation and output register.
  dtf_format #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_format (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_flags (rec_flags),
    .rec_int   (rec_int),
    .rec_frac  (rec_frac),
    .adv       (adv),
    .results   (results)
  );

endmodule

### sv/dtf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal text to fixed point: port checker
// Watches the top-level channels for reset behavior, flow control and the
// shape of saturated results.
// ----------------------------------------------------------------------------
module dtf_port_checker #(
  parameter int INT_BITS  = 16,
  parameter int FRAC_BITS = 16
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [INT_BITS+FRAC_BITS:0]        value,
  input logic                               overflow
);

  localparam int MW = INT_BITS + FRAC_BITS;
  localparam int TB = (MW > 63) ? 63 : MW;
  localparam int VW = MW + 1;
  localparam logic [TB:0] POSM = {1'b0, {TB{1'b1}}};
  localparam logic [TB:0] NEGM = {1'b1, {(TB-1){1'b0}}, 1'b1};

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A ready receiver always lets the next character in.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // A saturated result carries the full-scale magnitude.
  a_ovf_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |->
      (value == VW'(POSM)) || (value == VW'(NEGM)))
    else $error("overflow flag without full-scale value");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(value) && $stable(overflow)))
    else $error("result changed while stalled");

endmodule

bind decimal_text_to_fixed_point dtf_port_checker #(
  .INT_BITS  (INT_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_dtf_port_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (chars.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .value     (results.value),
  .overflow  (results.overflow)
);
